### rtl/sip_pkg.sv
// constants, widths and outcome codes for the segment intersection point unit
// no dependencies; used by segment_intersection_point_unit
package sip_pkg;

    localparam int COORD_BITS = 16;

    // line coefficient a/b, constant term c, side values and denominator
    localparam int AW  = COORD_BITS + 1;
    localparam int CW  = 2 * COORD_BITS + 2;
    localparam int RW  = 2 * COORD_BITS + 4;
    // signed numerator, unsigned rounded magnitude and divisor
    localparam int NW  = 3 * COORD_BITS + 4;
    localparam int MW  = 3 * COORD_BITS + 4;
    localparam int DW  = 2 * COORD_BITS + 3;

    // stream payload widths
    localparam int S_TDATA_W = ((8 * COORD_BITS) + 7) / 8 * 8;
    localparam int M_TDATA_W = ((2 + 2 * COORD_BITS) + 7) / 8 * 8;

    // outcome codes
    localparam logic [1:0] OUT_SEPARATE = 2'd0;
    localparam logic [1:0] OUT_CROSSING = 2'd1;
    localparam logic [1:0] OUT_PARALLEL = 2'd2;

endpackage

### rtl/segment_intersection_point_unit.sv
// segment intersection point: line equations, side tests and rounded crossing point
// depends on sip_pkg (widths, outcome codes)
// 5 arithmetic stages, COORD_BITS+1 divider stages and the output register;
//   one transaction per cycle unless stalled, one quotient bit in divider stages 1..W
// the whole pipeline advances whenever the output register is empty or being taken
// rst_n clears all valid bits asynchronously; payload registers are not reset
module segment_intersection_point_unit
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
    input  logic [sip_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // outcome, cross_x, cross_y
    output logic [sip_pkg::M_TDATA_W-1:0]  m_tdata
);

    localparam int W  = sip_pkg::COORD_BITS;
    localparam int AW = sip_pkg::AW;
    localparam int CW = sip_pkg::CW;
    localparam int RW = sip_pkg::RW;
    localparam int NW = sip_pkg::NW;
    localparam int MW = sip_pkg::MW;
    localparam int DW = sip_pkg::DW;

    logic adv;

    // input fields
    logic signed [W-1:0] x1, y1, x2, y2, x3, y3, x4, y4;
    assign x1 = s_tdata[0*W +: W];
    assign y1 = s_tdata[1*W +: W];
    assign x2 = s_tdata[2*W +: W];
    assign y2 = s_tdata[3*W +: W];
    assign x3 = s_tdata[4*W +: W];
    assign y3 = s_tdata[5*W +: W];
    assign x4 = s_tdata[6*W +: W];
    assign y4 = s_tdata[7*W +: W];

    // stage 1: coefficients a, b and the products of the constant terms
    logic                 v1_reg;
    logic signed [AW-1:0] a1_reg, b1_reg, a2_reg, b2_reg;
    logic signed [CW-1:0] p21_reg, p12_reg, p43_reg, p34_reg;
    logic signed [W-1:0]  x1_reg, y1_reg, x2_reg, y2_reg, x3_reg, y3_reg, x4_reg, y4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (adv)
            v1_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a1_reg  <= AW'(y2) - AW'(y1);
            b1_reg  <= AW'(x1) - AW'(x2);
            a2_reg  <= AW'(y4) - AW'(y3);
            b2_reg  <= AW'(x3) - AW'(x4);
            p21_reg <= CW'(x2) * CW'(y1);
            p12_reg <= CW'(x1) * CW'(y2);
            p43_reg <= CW'(x4) * CW'(y3);
            p34_reg <= CW'(x3) * CW'(y4);
            x1_reg <= x1; y1_reg <= y1; x2_reg <= x2; y2_reg <= y2;
            x3_reg <= x3; y3_reg <= y3; x4_reg <= x4; y4_reg <= y4;
        end
    end

    // stage 2: constant terms, side products and denominator products
    logic                 v2_reg;
    logic signed [CW-1:0] c1_reg, c2_reg;
    logic signed [AW-1:0] a1b_reg, b1b_reg, a2b_reg, b2b_reg;
    logic signed [RW-1:0] ax3_reg, by3_reg, ax4_reg, by4_reg;
    logic signed [RW-1:0] ax1_reg, by1_reg, ax2_reg, by2_reg;
    logic signed [RW-1:0] pd1_reg, pd2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (adv)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c1_reg  <= p21_reg - p12_reg;
            c2_reg  <= p43_reg - p34_reg;
            a1b_reg <= a1_reg; b1b_reg <= b1_reg; a2b_reg <= a2_reg; b2b_reg <= b2_reg;
            ax3_reg <= RW'(a1_reg) * RW'(x3_reg);
            by3_reg <= RW'(b1_reg) * RW'(y3_reg);
            ax4_reg <= RW'(a1_reg) * RW'(x4_reg);
            by4_reg <= RW'(b1_reg) * RW'(y4_reg);
            ax1_reg <= RW'(a2_reg) * RW'(x1_reg);
            by1_reg <= RW'(b2_reg) * RW'(y1_reg);
            ax2_reg <= RW'(a2_reg) * RW'(x2_reg);
            by2_reg <= RW'(b2_reg) * RW'(y2_reg);
            pd1_reg <= RW'(a1_reg) * RW'(b2_reg);
            pd2_reg <= RW'(a2_reg) * RW'(b1_reg);
        end
    end

    // stage 3: side values, denominator and numerator products
    logic                 v3_reg;
    logic signed [RW-1:0] r1_reg, r2_reg, r3_reg, r4_reg, den_reg;
    logic signed [NW-1:0] bc2_reg, b2c1_reg, a2c1_reg, a1c2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (adv)
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r3_reg   <= ax3_reg + by3_reg + RW'(c1_reg);
            r4_reg   <= ax4_reg + by4_reg + RW'(c1_reg);
            r1_reg   <= ax1_reg + by1_reg + RW'(c2_reg);
            r2_reg   <= ax2_reg + by2_reg + RW'(c2_reg);
            den_reg  <= pd1_reg - pd2_reg;
            bc2_reg  <= NW'(b1b_reg) * NW'(c2_reg);
            b2c1_reg <= NW'(b2b_reg) * NW'(c1_reg);
            a2c1_reg <= NW'(a2b_reg) * NW'(c1_reg);
            a1c2_reg <= NW'(a1b_reg) * NW'(c2_reg);
        end
    end

    // stage 4: outcome decision and numerators
    logic                 v4_reg;
    logic [1:0]           oc4_reg, oc4_next;
    logic signed [NW-1:0] nx_reg, ny_reg;
    logic signed [RW-1:0] den4_reg;
    logic                 same_b, same_a;

    assign same_b = (r3_reg != '0) && (r4_reg != '0) && (r3_reg[RW-1] == r4_reg[RW-1]);
    assign same_a = (r1_reg != '0) && (r2_reg != '0) && (r1_reg[RW-1] == r2_reg[RW-1]);

    always_comb
    begin
        if (same_b || same_a)
            oc4_next = sip_pkg::OUT_SEPARATE;
        else if (den_reg == '0)
            oc4_next = sip_pkg::OUT_PARALLEL;
        else
            oc4_next = sip_pkg::OUT_CROSSING;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else if (adv)
            v4_reg <= v3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            oc4_reg  <= oc4_next;
            nx_reg   <= bc2_reg - b2c1_reg;
            ny_reg   <= a2c1_reg - a1c2_reg;
            den4_reg <= den_reg;
        end
    end

    // stage 5: magnitudes plus half the divisor, quotient signs
    logic          v5_reg;
    logic [1:0]    oc5_reg;
    logic [MW-1:0] mx_reg, my_reg;
    logic [DW-1:0] d5_reg, d_next;
    logic          qnx_reg, qny_reg;
    logic [MW-1:0] nxa, nya;

    assign d_next = den4_reg[RW-1] ? DW'(-den4_reg) : DW'(den4_reg);
    assign nxa    = nx_reg[NW-1] ? MW'(-nx_reg) : MW'(nx_reg);
    assign nya    = ny_reg[NW-1] ? MW'(-ny_reg) : MW'(ny_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v5_reg <= 1'b0;
        else if (adv)
            v5_reg <= v4_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            oc5_reg <= oc4_reg;
            d5_reg  <= d_next;
            mx_reg  <= nxa + MW'(d_next >> 1);
            my_reg  <= nya + MW'(d_next >> 1);
            qnx_reg <= nx_reg[NW-1] != den4_reg[RW-1];
            qny_reg <= ny_reg[NW-1] != den4_reg[RW-1];
        end
    end

    // divider stage 0: overflow test on the high part, remainder seed
    logic              vd_reg   [0:W];
    logic [1:0]        ocd_reg  [0:W];
    logic [DW-1:0]     dd_reg   [0:W];
    logic              qnxd_reg [0:W];
    logic              qnyd_reg [0:W];
    logic              ovx_reg  [0:W];
    logic              ovy_reg  [0:W];
    logic [DW-1:0]     remx_reg [0:W];
    logic [DW-1:0]     remy_reg [0:W];
    logic [W-1:0]      lowx_reg [0:W];
    logic [W-1:0]      lowy_reg [0:W];
    logic [W-1:0]      qx_reg   [0:W];
    logic [W-1:0]      qy_reg   [0:W];
    logic              ovx_next, ovy_next;

    assign ovx_next = mx_reg[MW-1:W] >= (MW-W)'(d5_reg);
    assign ovy_next = my_reg[MW-1:W] >= (MW-W)'(d5_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= W; k++)
                vd_reg[k] <= 1'b0;
        end
        else if (adv)
        begin
            vd_reg[0] <= v5_reg;
            for (int k = 1; k <= W; k++)
                vd_reg[k] <= vd_reg[k-1];
        end
    end

    // divider stages 1..W: one restoring quotient bit per stage
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ocd_reg[0]  <= oc5_reg;
            dd_reg[0]   <= d5_reg;
            qnxd_reg[0] <= qnx_reg;
            qnyd_reg[0] <= qny_reg;
            ovx_reg[0]  <= ovx_next;
            ovy_reg[0]  <= ovy_next;
            remx_reg[0] <= ovx_next ? '0 : mx_reg[W +: DW];
            remy_reg[0] <= ovy_next ? '0 : my_reg[W +: DW];
            lowx_reg[0] <= mx_reg[W-1:0];
            lowy_reg[0] <= my_reg[W-1:0];
            qx_reg[0]   <= '0;
            qy_reg[0]   <= '0;
            for (int k = 1; k <= W; k++)
            begin
                ocd_reg[k]  <= ocd_reg[k-1];
                dd_reg[k]   <= dd_reg[k-1];
                qnxd_reg[k] <= qnxd_reg[k-1];
                qnyd_reg[k] <= qnyd_reg[k-1];
                ovx_reg[k]  <= ovx_reg[k-1];
                ovy_reg[k]  <= ovy_reg[k-1];
                lowx_reg[k] <= lowx_reg[k-1] << 1;
                lowy_reg[k] <= lowy_reg[k-1] << 1;
                if ({remx_reg[k-1], lowx_reg[k-1][W-1]} >= (DW+1)'(dd_reg[k-1]))
                begin
                    remx_reg[k] <= DW'({remx_reg[k-1], lowx_reg[k-1][W-1]}
                                       - (DW+1)'(dd_reg[k-1]));
                    qx_reg[k]   <= {qx_reg[k-1][W-2:0], 1'b1};
                end
                else
                begin
                    remx_reg[k] <= DW'({remx_reg[k-1], lowx_reg[k-1][W-1]});
                    qx_reg[k]   <= {qx_reg[k-1][W-2:0], 1'b0};
                end
                if ({remy_reg[k-1], lowy_reg[k-1][W-1]} >= (DW+1)'(dd_reg[k-1]))
                begin
                    remy_reg[k] <= DW'({remy_reg[k-1], lowy_reg[k-1][W-1]}
                                       - (DW+1)'(dd_reg[k-1]));
                    qy_reg[k]   <= {qy_reg[k-1][W-2:0], 1'b1};
                end
                else
                begin
                    remy_reg[k] <= DW'({remy_reg[k-1], lowy_reg[k-1][W-1]});
                    qy_reg[k]   <= {qy_reg[k-1][W-2:0], 1'b0};
                end
            end
        end
    end

    // saturation, sign and zeroing for a non-crossing outcome
    logic [W-1:0] limx, limy, satx, saty, cx_next, cy_next;
    logic         is_crossing;

    assign limx  = qnxd_reg[W] ? W'(1) << (W-1) : (W'(1) << (W-1)) - W'(1);
    assign limy  = qnyd_reg[W] ? W'(1) << (W-1) : (W'(1) << (W-1)) - W'(1);
    assign satx  = (ovx_reg[W] || qx_reg[W] > limx) ? limx : qx_reg[W];
    assign saty  = (ovy_reg[W] || qy_reg[W] > limy) ? limy : qy_reg[W];
    assign is_crossing = ocd_reg[W] == sip_pkg::OUT_CROSSING;
    assign cx_next = !is_crossing ? '0 : (qnxd_reg[W] ? -satx : satx);
    assign cy_next = !is_crossing ? '0 : (qnyd_reg[W] ? -saty : saty);

    // output register
    logic         out_v_reg;
    logic [1:0]   oc_reg;
    logic [W-1:0] cx_reg, cy_reg;

    assign adv      = !out_v_reg || m_tready;
    assign s_tready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (adv)
            out_v_reg <= vd_reg[W];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            oc_reg <= ocd_reg[W];
            cx_reg <= cx_next;
            cy_reg <= cy_next;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = sip_pkg::M_TDATA_W'({cy_reg, cx_reg, oc_reg});

    // checks
    a_no_code3: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> oc_reg != 2'd3)
        else $error("invalid outcome code");

    a_zero_point: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && oc_reg != sip_pkg::OUT_CROSSING) |-> (cx_reg == '0 && cy_reg == '0))
        else $error("crossing point not zero without a crossing");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> ($stable(vd_reg[W]) && $stable(v5_reg) && $stable(v1_reg)))
        else $error("pipeline moved while stalled");

endmodule

### test/segment_intersection_point_unit_tb.sv
// testbench for segment_intersection_point_unit: directed table then random segment pairs
// depends on sip_pkg and the unit; results are checked against typed table values or an in-bench crossing predictor
`timescale 1ns / 1ps

module segment_intersection_point_unit_tb;

    typedef logic signed [sip_pkg::COORD_BITS-1:0] coord_t;

    typedef struct {
        logic [1:0] outcome;
        coord_t     cross_x;
        coord_t     cross_y;
    } crossing_t;

    typedef struct {
        coord_t    pt [8];
        bit        typed;
        crossing_t known;
    } table_row_t;

    localparam int N_RANDOM    = 1630;
    localparam int CYCLE_LIMIT = 600000;

    logic                          clk;
    logic                          rst_n;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [sip_pkg::S_TDATA_W-1:0] s_tdata;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [sip_pkg::M_TDATA_W-1:0] m_tdata;

    crossing_t pending_crossings [$];
    int        error_count;
    int        cycle_count;
    int        stall_left;
    table_row_t directed_rows [$];

    segment_intersection_point_unit u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // clock
    always #10 clk = ~clk;

    function automatic bit strictly_same_side(longint r, longint s);
        return r != 0 && s != 0 && ((r < 0) == (s < 0));
    endfunction

    // rounded division, half the divisor magnitude added away from zero, saturated
    function automatic coord_t rounded_quotient(longint num, longint den);
        longint mag_n;
        longint mag_d;
        longint q;
        longint lim;
        bit     neg_q;
        begin
            mag_n = (num < 0) ? -num : num;
            mag_d = (den < 0) ? -den : den;
            neg_q = (num < 0) != (den < 0);
            q     = (mag_n + mag_d / 2) / mag_d;
            lim   = neg_q ? (64'sd1 <<< (sip_pkg::COORD_BITS - 1))
                          : (64'sd1 <<< (sip_pkg::COORD_BITS - 1)) - 1;
            if (q > lim)
                q = lim;
            return coord_t'(neg_q ? -q : q);
        end
    endfunction

    // crossing point of segment a and segment b
    function automatic crossing_t predict_crossing(coord_t pt [8]);
        longint x1, y1, x2, y2, x3, y3, x4, y4;
        longint a1, b1, c1, a2, b2, c2, den;
        crossing_t res;
        begin
            x1 = pt[0]; y1 = pt[1]; x2 = pt[2]; y2 = pt[3];
            x3 = pt[4]; y3 = pt[5]; x4 = pt[6]; y4 = pt[7];
            res = '{sip_pkg::OUT_SEPARATE, '0, '0};
            a1 = y2 - y1;
            b1 = x1 - x2;
            c1 = x2 * y1 - x1 * y2;
            if (strictly_same_side(a1 * x3 + b1 * y3 + c1, a1 * x4 + b1 * y4 + c1))
                return res;
            a2 = y4 - y3;
            b2 = x3 - x4;
            c2 = x4 * y3 - x3 * y4;
            if (strictly_same_side(a2 * x1 + b2 * y1 + c2, a2 * x2 + b2 * y2 + c2))
                return res;
            den = a1 * b2 - a2 * b1;
            if (den == 0)
            begin
                res.outcome = sip_pkg::OUT_PARALLEL;
                return res;
            end
            res.outcome = sip_pkg::OUT_CROSSING;
            res.cross_x = rounded_quotient(b1 * c2 - b2 * c1, den);
            res.cross_y = rounded_quotient(a2 * c1 - a1 * c2, den);
            return res;
        end
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        begin
            error_count++;
            $display("mismatch at %0t: %s got %0d expected %0d", $realtime, field, got, want);
        end
    endtask

    // random coordinate: small window, full range or an extreme value
    function automatic coord_t pick_coord(int mode);
        int pick;
        begin
            case (mode)
                0: return coord_t'($urandom_range(128) - 64);
                1: return coord_t'($urandom);
                default:
                begin
                    pick = $urandom_range(5);
                    case (pick)
                        0: return coord_t'(-32768);
                        1: return coord_t'(-32767);
                        2: return coord_t'(-1);
                        3: return coord_t'(0);
                        4: return coord_t'(1);
                        default: return coord_t'(32767);
                    endcase
                end
            endcase
        end
    endfunction

    // drive one transaction, with an optional idle gap first
    task automatic send_pair(coord_t pt [8], bit typed, crossing_t known);
        int gap;
        begin
            gap = ($urandom_range(9) < 6) ? 0 :
                  ($urandom_range(19) == 0) ? $urandom_range(40, 12) : $urandom_range(3, 1);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= {pt[7], pt[6], pt[5], pt[4], pt[3], pt[2], pt[1], pt[0]};
            do
                @(posedge clk);
            while (!s_tready);
            pending_crossings.push_back(typed ? known : predict_crossing(pt));
        end
    endtask

    task automatic add_row(int p0, int p1, int p2, int p3, int p4, int p5, int p6, int p7,
                           bit typed, logic [1:0] oc, int cx, int cy);
        table_row_t row;
        begin
            row.pt = '{coord_t'(p0), coord_t'(p1), coord_t'(p2), coord_t'(p3),
                       coord_t'(p4), coord_t'(p5), coord_t'(p6), coord_t'(p7)};
            row.typed = typed;
            row.known = '{oc, coord_t'(cx), coord_t'(cy)};
            directed_rows.push_back(row);
        end
    endtask

    // receiver: random stalls, and result checking
    always @(posedge clk)
    begin
        crossing_t want;
        crossing_t got;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
        begin
            if (m_tvalid && m_tready && rst_n)
            begin
                got.outcome = m_tdata[1:0];
                got.cross_x = m_tdata[2 +: sip_pkg::COORD_BITS];
                got.cross_y = m_tdata[2 + sip_pkg::COORD_BITS +: sip_pkg::COORD_BITS];
                if (pending_crossings.size() == 0)
                    report_mismatch("unexpected transaction, outcome", got.outcome, -1);
                else
                begin
                    want = pending_crossings.pop_front();
                    if (got.outcome !== want.outcome)
                        report_mismatch("outcome", got.outcome, want.outcome);
                    if (got.cross_x !== want.cross_x)
                        report_mismatch("cross_x", got.cross_x, want.cross_x);
                    if (got.cross_y !== want.cross_y)
                        report_mismatch("cross_y", got.cross_y, want.cross_y);
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if ($urandom_range(9) < 2)
            begin
                stall_left = ($urandom_range(24) == 0) ? $urandom_range(50, 10) : $urandom_range(2);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin
        int        mode;
        coord_t    pt [8];
        crossing_t none;
        clk         = 1'b0;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        m_tready    = 1'b0;
        error_count = 0;
        cycle_count = 0;
        stall_left  = 0;
        none        = '{sip_pkg::OUT_SEPARATE, '0, '0};

        // directed table: typed where obvious, predictor elsewhere
        add_row(0, 0, 10, 10, 0, 10, 10, 0, 1, sip_pkg::OUT_CROSSING, 5, 5);
        add_row(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
                1, sip_pkg::OUT_PARALLEL, 0, 0);
        add_row(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767,
                1, sip_pkg::OUT_PARALLEL, 0, 0);
        add_row(0, 0, 10, 0, 0, 5, 10, 5, 1, sip_pkg::OUT_SEPARATE, 0, 0);
        add_row(0, 0, 10, 0, 5, 0, 20, 0, 1, sip_pkg::OUT_PARALLEL, 0, 0);
        add_row(0, 0, 10, 0, 20, 5, 30, -5, 1, sip_pkg::OUT_SEPARATE, 0, 0);
        add_row(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768, 0, 0, 0, 0);
        add_row(-32768, 0, 32767, 0, 0, -32768, 0, 32767, 0, 0, 0, 0);
        add_row(-32768, -32768, 32767, 32767, 32767, -32768, -32768, 32767, 0, 0, 0, 0);
        add_row(0, 0, 10, 0, 5, 0, 5, 9, 0, 0, 0, 0);
        add_row(0, 0, 3, 1, 0, 1, 3, 0, 0, 0, 0, 0);
        add_row(0, 0, 7, 2, 1, 3, 4, -5, 0, 0, 0, 0);
        add_row(-1, -1, 1, 1, -1, 1, 1, -1, 0, 0, 0, 0);
        add_row(5, 5, 5, 5, 0, 0, 10, 10, 0, 0, 0, 0);
        add_row(-32767, 1, 32767, -1, 1, -32767, -1, 32767, 0, 0, 0, 0);
        add_row(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767, 0, 0, 0, 0);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_pair(directed_rows[i].pt, directed_rows[i].typed, directed_rows[i].known);

        // random pairs, mostly small windows where crossings are common
        for (int n = 0; n < N_RANDOM; n++)
        begin
            mode = ($urandom_range(9) < 6) ? 0 : ($urandom_range(2) == 0) ? 2 : 1;
            foreach (pt[k])
                pt[k] = pick_coord(($urandom_range(7) == 0) ? $urandom_range(2) : mode);
            if (n == N_RANDOM / 2)
            begin
                // hold off until the pipeline has drained
                s_tvalid <= 1'b0;
                while (pending_crossings.size() != 0)
                    @(posedge clk);
            end
            send_pair(pt, 1'b0, none);
        end
        s_tvalid <= 1'b0;

        while (pending_crossings.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### sim.f
rtl/sip_pkg.sv
rtl/segment_intersection_point_unit.sv
test/segment_intersection_point_unit_tb.sv
